### rtl/core/dttss_pkg.sv
// shared types, constants and register codes for the two-tone siren core
`timescale 1ns / 1ps

package dttss_pkg;

  // field and register widths
  localparam int DEBOUNCE_W = 20;
  localparam int HALF_W     = 23;
  localparam int PERIOD_W   = 16;
  localparam int STEP_W     = 24;
  localparam int CYCLE_W    = 24;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 4;

  // default tone time width
  localparam int TIME_BITS_DEF = 24;

  // register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(20000);
  localparam logic [HALF_W-1:0]     HALF_RST     = HALF_W'(250000);
  localparam logic [PERIOD_W-1:0]   FIRST_RST    = PERIOD_W'(1428);
  localparam logic [PERIOD_W-1:0]   SECOND_RST   = PERIOD_W'(834);

  // register index codes, word addresses
  typedef enum logic [1:0] {
    REG_DEBOUNCE,
    REG_HALF,
    REG_FIRST,
    REG_SECOND
  } reg_idx_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_TONE,
    S_PHASE,
    S_FINISH
  } state_t;

  // status of the shared modulo unit
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

### rtl/core/dttss_mod_unit.sv
// shared restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps

module dttss_mod_unit #(
  parameter int DVD_W = dttss_pkg::TIME_BITS_DEF + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [DVD_W-1:0]               dividend,
  input  logic [dttss_pkg::CYCLE_W-1:0]  divisor,
  output logic [dttss_pkg::CYCLE_W-1:0]  remainder,
  output dttss_pkg::mod_status_t         status
);

  localparam int DIV_W = dttss_pkg::CYCLE_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] count;
  logic             done;
  logic [DIV_W-1:0] rem;
  logic [DVD_W-1:0] dvd;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] rem_next;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem, dvd[DVD_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = DIV_W'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[DIV_W-1:0];
    end
  end

  // control counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= CNT_W'(DVD_W);
      end else if (count != '0) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // operand and remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (count != '0) begin
      rem <= rem_next;
      dvd <= {dvd[DVD_W-2:0], 1'b0};
    end
  end

  assign remainder   = rem;
  assign status.busy = (count != '0);
  assign status.done = done;

endmodule

### rtl/core/debounced_toggle_two_tone_siren_core.sv
// top level of the debounced toggle two-tone siren core
// usage:
//   input channel (in_valid, in_stall, op, key_level, step_us) carries one item per
//   transfer: op high is a start event, op low is an update with elapsed time.
//   output channel (out_valid, out_stall, siren_out, sounding_now) returns exactly
//   one result per accepted item, in order, from an output register.
//   the apb port writes and reads the four timing registers at byte addresses
//   0, 4, 8 and 12; writes are expected only while the core is idle.
// sequencing:
//   an item that leaves the siren silent goes from S_IDLE to S_FINISH and loads its
//   result from there; an item with the siren sounding runs two remainder passes on
//   the shared one-bit-per-cycle unit, S_TONE and then S_PHASE, before S_FINISH;
//   when the selected period is zero only the S_TONE pass runs.
//   in_stall is high from the transfer until the result is loaded.
// reset: rst clears the sequencer, debounce state, tone time and siren, and
//   loads the default timing registers; no clearing pass is needed.
// stall: a finished result waits in the sequencer while out_stall holds the
//   previous one; the output payload holds until it is taken.
`timescale 1ns / 1ps

module debounced_toggle_two_tone_siren_core #(
  parameter int TIME_BITS = dttss_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic                              key_level,
  input  logic [dttss_pkg::STEP_W-1:0]      step_us,
  // output channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              siren_out,
  output logic                              sounding_now,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dttss_pkg::APB_AW-1:0]      paddr,
  input  logic [dttss_pkg::APB_DW-1:0]      pwdata,
  output logic [dttss_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);

  localparam int DB_W  = dttss_pkg::DEBOUNCE_W;
  localparam int HF_W  = dttss_pkg::HALF_W;
  localparam int PR_W  = dttss_pkg::PERIOD_W;
  localparam int CY_W  = dttss_pkg::CYCLE_W;
  localparam int ST_W  = dttss_pkg::STEP_W;
  localparam int SUM_W = ((TIME_BITS > ST_W) ? TIME_BITS : ST_W) + 1;

  // configuration registers
  logic [DB_W-1:0] debounce_us;
  logic [HF_W-1:0] half_cycle_us;
  logic [PR_W-1:0] first_period_us;
  logic [PR_W-1:0] second_period_us;

  // block state
  logic [TIME_BITS-1:0] tone_time;
  logic [DB_W-1:0]      key_timer;
  logic                 siren_on;
  logic                 key_candidate_level;
  logic                 key_stable_level;

  dttss_pkg::state_t state;
  dttss_pkg::state_t state_next;
  logic [PR_W-1:0]   period;
  logic              pin;

  logic accept;
  logic cfg_write;

  // modulo unit interface
  logic                   mod_start;
  logic [SUM_W-1:0]       mod_dividend;
  logic [CY_W-1:0]        mod_divisor;
  logic [CY_W-1:0]        mod_rem;
  dttss_pkg::mod_status_t mod_status;

  assign accept    = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us      <= dttss_pkg::DEBOUNCE_RST;
      half_cycle_us    <= dttss_pkg::HALF_RST;
      first_period_us  <= dttss_pkg::FIRST_RST;
      second_period_us <= dttss_pkg::SECOND_RST;
    end else if (cfg_write) begin
      case (dttss_pkg::reg_idx_t'(paddr[3:2]))
        dttss_pkg::REG_DEBOUNCE: debounce_us      <= pwdata[DB_W-1:0];
        dttss_pkg::REG_HALF:     half_cycle_us    <= pwdata[HF_W-1:0];
        dttss_pkg::REG_FIRST:    first_period_us  <= pwdata[PR_W-1:0];
        dttss_pkg::REG_SECOND:   second_period_us <= pwdata[PR_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration readback
  always_comb begin
    case (dttss_pkg::reg_idx_t'(paddr[3:2]))
      dttss_pkg::REG_DEBOUNCE: prdata = dttss_pkg::APB_DW'(debounce_us);
      dttss_pkg::REG_HALF:     prdata = dttss_pkg::APB_DW'(half_cycle_us);
      dttss_pkg::REG_FIRST:    prdata = dttss_pkg::APB_DW'(first_period_us);
      dttss_pkg::REG_SECOND:   prdata = dttss_pkg::APB_DW'(second_period_us);
      default:                 prdata = '0;
    endcase
  end

  // tone cycle length, zero half cycle counts as one
  logic [HF_W-1:0] half_eff;
  logic [CY_W-1:0] cycle;
  assign half_eff = (half_cycle_us == '0) ? HF_W'(1) : half_cycle_us;
  assign cycle    = {half_eff, 1'b0};

  // debounce update for an update item
  logic            cand_change;
  logic            below;
  logic [DB_W-1:0] gap;
  logic            sat;
  logic [DB_W-1:0] timer_upd;
  logic            press;
  logic            stable_upd;
  logic            siren_upd;
  logic [TIME_BITS-1:0] tone_base;

  always_comb begin
    cand_change = (key_level != key_candidate_level);
    below       = (key_timer < debounce_us);
    gap         = debounce_us - key_timer;
    sat         = (step_us >= ST_W'(gap));
    stable_upd  = key_stable_level;
    press       = 1'b0;
    if (cand_change) begin
      timer_upd = '0;
    end else if (below) begin
      timer_upd = sat ? debounce_us : DB_W'(key_timer + step_us[DB_W-1:0]);
      if (sat && (key_stable_level != key_candidate_level)) begin
        stable_upd = key_candidate_level;
        press      = key_candidate_level;
      end
    end else begin
      timer_upd = key_timer;
    end
    siren_upd = press ? !siren_on : siren_on;
    tone_base = press ? '0 : tone_time;
  end

  // tone half selection from the fresh remainder
  logic [TIME_BITS-1:0] tt_new;
  logic [SUM_W-1:0]     tt_ext;
  logic [SUM_W-1:0]     half_ext;
  logic                 upper;
  logic [CY_W-1:0]      phase;
  logic [PR_W-1:0]      period_sel;
  logic                 pin_phase;

  always_comb begin
    tt_ext     = SUM_W'(mod_rem);
    tt_new     = tt_ext[TIME_BITS-1:0];
    half_ext   = SUM_W'(half_eff);
    upper      = (SUM_W'(tt_new) >= half_ext);
    phase      = upper ? CY_W'(SUM_W'(tt_new) - half_ext) : CY_W'(tt_new);
    period_sel = upper ? second_period_us : first_period_us;
    pin_phase  = (mod_rem < CY_W'(period[PR_W-1:1]));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dttss_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (!op && siren_upd) ? dttss_pkg::S_TONE : dttss_pkg::S_FINISH;
        end
      end
      dttss_pkg::S_TONE: begin
        if (mod_status.done) begin
          state_next = (period_sel == '0) ? dttss_pkg::S_FINISH : dttss_pkg::S_PHASE;
        end
      end
      dttss_pkg::S_PHASE: begin
        if (mod_status.done) begin
          state_next = dttss_pkg::S_FINISH;
        end
      end
      dttss_pkg::S_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = dttss_pkg::S_IDLE;
        end
      end
      default: state_next = dttss_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall     = 1'b1;
    mod_start    = 1'b0;
    mod_dividend = SUM_W'(phase);
    mod_divisor  = CY_W'(period_sel);
    case (state)
      dttss_pkg::S_IDLE: begin
        in_stall     = 1'b0;
        mod_start    = accept && !op && siren_upd;
        mod_dividend = SUM_W'(tone_base) + SUM_W'(step_us);
        mod_divisor  = cycle;
      end
      dttss_pkg::S_TONE: begin
        mod_start = mod_status.done && (period_sel != '0);
      end
      default: ;
    endcase
  end

  // sequencer and block state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= dttss_pkg::S_IDLE;
      tone_time           <= '0;
      key_timer           <= '0;
      siren_on            <= 1'b0;
      key_candidate_level <= 1'b0;
      key_stable_level    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (op) begin
          key_candidate_level <= key_level;
          key_stable_level    <= key_level;
          tone_time           <= '0;
          key_timer           <= '0;
          siren_on            <= 1'b0;
        end else begin
          key_candidate_level <= key_level;
          key_stable_level    <= stable_upd;
          key_timer           <= timer_upd;
          siren_on            <= siren_upd;
          tone_time           <= tone_base;
        end
      end else if (state == dttss_pkg::S_TONE && mod_status.done) begin
        tone_time <= tt_new;
      end
    end
  end

  // result pin and selected period
  always_ff @(posedge clk) begin
    if (accept) begin
      pin <= 1'b0;
    end else if (state == dttss_pkg::S_TONE && mod_status.done) begin
      period <= period_sel;
      pin    <= 1'b0;
    end else if (state == dttss_pkg::S_PHASE && mod_status.done) begin
      pin <= pin_phase;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == dttss_pkg::S_FINISH && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dttss_pkg::S_FINISH && (!out_valid || !out_stall)) begin
      siren_out    <= pin;
      sounding_now <= siren_on;
    end
  end

  // shared remainder unit
  dttss_mod_unit #(
    .DVD_W (SUM_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .remainder (mod_rem),
    .status    (mod_status)
  );

  // a high siren pin only comes with the siren on
  a_pin_needs_siren: assert property (@(posedge clk) disable iff (rst)
    out_valid && siren_out |-> sounding_now)
    else $error("siren pin high while siren off");

  // an accepted item holds off the next one
  a_accept_stalls: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input not stalled after transfer");

  // the remainder unit is never restarted mid-pass
  a_mod_start_idle: assert property (@(posedge clk) disable iff (rst)
    mod_start |-> !mod_status.busy)
    else $error("remainder unit restarted while busy");

  // a remainder only completes while the sequencer waits for it
  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_status.done |-> (state == dttss_pkg::S_TONE || state == dttss_pkg::S_PHASE))
    else $error("remainder done outside a wait state");

  // a finished item with a free output slot is presented next cycle
  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    state == dttss_pkg::S_FINISH && !out_valid |=> out_valid)
    else $error("finished result not loaded");

endmodule
